### design/bqc_pkg.sv
// Package for the cascaded biquad filter: widths, microcode word layout,
// the sequencer program and the fixed coefficient table.
// No dependencies; used by every module of the block.
package bqc_pkg;

  // Default number of sections and the fixed field widths.
  localparam int unsigned SectionsDef = 5;
  localparam int unsigned SectionsMax = 8;
  localparam int unsigned SampleW     = 16;
  localparam int unsigned DataW       = 32;
  localparam int unsigned AccW        = 64;
  localparam int unsigned PcW         = 3;
  localparam int unsigned RomSecW     = 3;

  // Operand selected for the multiplier.
  typedef enum logic [2:0] {
    OPND_X  = 3'd0,
    OPND_X1 = 3'd1,
    OPND_X2 = 3'd2,
    OPND_Y1 = 3'd3,
    OPND_Y2 = 3'd4
  } opnd_e;

  // Coefficient selected within the current section's row.
  typedef enum logic [2:0] {
    COEF_B0 = 3'd0,
    COEF_B1 = 3'd1,
    COEF_B2 = 3'd2,
    COEF_A1 = 3'd3,
    COEF_A2 = 3'd4
  } coef_e;

  // Accumulator operation on the registered product.
  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2,
    ACC_SUB  = 2'd3
  } acc_e;

  // One microcode control word.
  typedef struct packed {
    opnd_e          opnd;
    coef_e          coef;
    acc_e           acc;
    logic           commit;   // round, saturate, shift history, next section
    logic           done;     // final rounding and result hand-off
    logic [PcW-1:0] jump_tgt; // target taken at commit while sections remain
  } uword_t;

  // Program step names.
  localparam logic [PcW-1:0] StepSecStart = 3'd0;

  localparam uword_t UwordIdle = '{
    opnd: OPND_X, coef: COEF_B0, acc: ACC_HOLD, commit: 1'b0, done: 1'b0,
    jump_tgt: StepSecStart
  };

  // The program. The multiplier result is registered, so each product is
  // accumulated in the step after the one that issues it.
  function automatic uword_t ucode(logic [PcW-1:0] pc);
    uword_t w;
    w = UwordIdle;
    case (pc)
      3'd0: begin
        w.opnd = OPND_X;  w.coef = COEF_B0; w.acc = ACC_HOLD;
      end
      3'd1: begin
        w.opnd = OPND_X1; w.coef = COEF_B1; w.acc = ACC_LOAD;
      end
      3'd2: begin
        w.opnd = OPND_X2; w.coef = COEF_B2; w.acc = ACC_ADD;
      end
      3'd3: begin
        w.opnd = OPND_Y1; w.coef = COEF_A1; w.acc = ACC_ADD;
      end
      3'd4: begin
        w.opnd = OPND_Y2; w.coef = COEF_A2; w.acc = ACC_SUB;
      end
      3'd5: begin
        w.acc = ACC_SUB;
      end
      3'd6: begin
        w.commit   = 1'b1;
        w.jump_tgt = StepSecStart;
      end
      3'd7: begin
        w.done = 1'b1;
      end
      default: begin
        w = UwordIdle;
      end
    endcase
    return w;
  endfunction

  // Coefficients in Q3.29. Sections beyond the fifth pass the signal through.
  localparam logic signed [DataW-1:0] CoefOne = 32'sd536870912;

  function automatic logic signed [DataW-1:0] coef_rom(logic [RomSecW-1:0] sec,
                                                       coef_e idx);
    logic signed [DataW-1:0] b0, b1, b2, a1, a2;
    logic signed [DataW-1:0] c;
    b0 = CoefOne;
    b1 = '0;
    b2 = '0;
    a1 = '0;
    a2 = '0;
    case (sec)
      3'd0: begin
        b0 = 32'sd1421956;   b1 = 32'sd2843913;    b2 = 32'sd1421956;
        a1 = -32'sd518076532; a2 = 32'sd166719372;
      end
      3'd1: begin
        b1 = 32'sd1073741824; b2 = CoefOne;
        a1 = -32'sd636635003; a2 = 32'sd358636281;
      end
      3'd2: begin
        b2 = -32'sd536870912;
        a1 = -32'sd759250124; a2 = 32'sd234832153;
      end
      3'd3: begin
        b1 = -32'sd1073741824; b2 = CoefOne;
        a1 = -32'sd1039092685; a2 = 32'sd503127652;
      end
      3'd4: begin
        b1 = -32'sd1073741824; b2 = CoefOne;
        a1 = -32'sd1061021639; a2 = 32'sd524982029;
      end
      default: begin
        b0 = CoefOne;
      end
    endcase
    case (idx)
      COEF_B0: c = b0;
      COEF_B1: c = b1;
      COEF_B2: c = b2;
      COEF_A1: c = a1;
      COEF_A2: c = a2;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

### design/bqc_sequencer.sv
// Microcode sequencer: step counter, section counter and program ROM.
// Depends on bqc_pkg for the control word and the program.
module bqc_sequencer #(
  parameter int unsigned SECTIONS = bqc_pkg::SectionsDef,
  localparam int unsigned SecW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               stall_i,
  output logic               busy_o,
  output logic [SecW-1:0]    sec_o,
  output bqc_pkg::uword_t    ctrl_o
);
  import bqc_pkg::*;

  localparam logic [SecW-1:0] SecLast = SecW'(SECTIONS - 1);

  logic           busy_q, busy_d;
  logic [PcW-1:0] pc_q, pc_d;
  logic [SecW-1:0] sec_q, sec_d;
  uword_t         word;

  // Control word of the current step; idle word while nothing is running.
  always_comb begin
    word = busy_q ? ucode(pc_q) : UwordIdle;
  end

  // Step and section advance, with the loop back over sections.
  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    sec_d  = sec_q;
    if (start_i) begin
      busy_d = 1'b1;
      pc_d   = StepSecStart;
      sec_d  = '0;
    end else if (busy_q) begin
      if (word.commit) begin
        if (sec_q != SecLast) begin
          sec_d = sec_q + 1'b1;
          pc_d  = word.jump_tgt;
        end else begin
          pc_d = pc_q + 1'b1;
        end
      end else if (word.done) begin
        if (!stall_i) begin
          busy_d = 1'b0;
        end
      end else begin
        pc_d = pc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= StepSecStart;
      sec_q  <= '0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
      sec_q  <= sec_d;
    end
  end

  assign busy_o = busy_q;
  assign sec_o  = sec_q;
  assign ctrl_o = word;

endmodule

### design/bqc_datapath.sv
// Datapath: section history, shared multiplier and accumulator, rounding
// and saturation. Driven by the control word from bqc_sequencer; uses bqc_pkg.
module bqc_datapath #(
  parameter int unsigned SECTIONS = bqc_pkg::SectionsDef,
  localparam int unsigned SecW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic                                 clear_i,
  input  logic signed [bqc_pkg::SampleW-1:0]   sample_i,
  input  bqc_pkg::uword_t                      ctrl_i,
  input  logic [SecW-1:0]                      sec_i,
  output logic signed [bqc_pkg::SampleW-1:0]   sample_o,
  output logic                                 clipped_o
);
  import bqc_pkg::*;

  localparam int unsigned RndW = AccW - 29;   // width after the shift by 29
  localparam int unsigned FinW = DataW + 1;

  // Section history, Q8.24.
  logic signed [DataW-1:0] x1_q [SECTIONS];
  logic signed [DataW-1:0] x2_q [SECTIONS];
  logic signed [DataW-1:0] y1_q [SECTIONS];
  logic signed [DataW-1:0] y2_q [SECTIONS];

  logic signed [DataW-1:0] x_q;      // input of the current section
  logic signed [AccW-1:0]  prod_q;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic                    clip_q;

  logic signed [DataW-1:0] opnd;
  logic signed [DataW-1:0] coef;
  logic signed [AccW-1:0]  rnd_sum;
  logic signed [RndW-1:0]  rnd_val;
  logic signed [DataW-1:0] sec_y;
  logic                    sec_sat;
  logic signed [FinW-1:0]  fin_sum;
  logic signed [FinW-10:0] fin_val;
  logic                    fin_sat;

  // Operand and coefficient selection for the multiplier.
  always_comb begin
    case (ctrl_i.opnd)
      OPND_X:  opnd = x_q;
      OPND_X1: opnd = x1_q[sec_i];
      OPND_X2: opnd = x2_q[sec_i];
      OPND_Y1: opnd = y1_q[sec_i];
      OPND_Y2: opnd = y2_q[sec_i];
      default: opnd = '0;
    endcase
    coef = coef_rom(RomSecW'(sec_i), ctrl_i.coef);
  end

  // Accumulator update from the registered product.
  always_comb begin
    case (ctrl_i.acc)
      ACC_HOLD: acc_d = acc_q;
      ACC_LOAD: acc_d = prod_q;
      ACC_ADD:  acc_d = acc_q + prod_q;
      ACC_SUB:  acc_d = acc_q - prod_q;
      default:  acc_d = acc_q;
    endcase
  end

  // Section output: round half up to Q8.24, then saturate to 32 bits.
  always_comb begin
    rnd_sum = acc_q + (AccW'(1) <<< 28);
    rnd_val = rnd_sum[AccW-1:29];
    sec_sat = (rnd_val[RndW-1:DataW-1] != {(RndW-DataW+1){rnd_val[RndW-1]}});
    if (sec_sat) begin
      sec_y = rnd_val[RndW-1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      sec_y = rnd_val[DataW-1:0];
    end
  end

  // Final output: round half up to Q1.15, then saturate to 16 bits.
  always_comb begin
    fin_sum = {x_q[DataW-1], x_q} + FinW'(256);
    fin_val = fin_sum[FinW-1:9];
    fin_sat = (fin_val[FinW-10:SampleW-1] != {(FinW-9-SampleW+1){fin_val[FinW-10]}});
    if (fin_sat) begin
      sample_o = fin_val[FinW-10] ? {1'b1, {(SampleW-1){1'b0}}}
                                  : {1'b0, {(SampleW-1){1'b1}}};
    end else begin
      sample_o = fin_val[SampleW-1:0];
    end
    clipped_o = clip_q | fin_sat;
  end

  // Multiplier and accumulator registers; payload only, no reset needed.
  always_ff @(posedge clk_i) begin
    prod_q <= AccW'(opnd) * AccW'(coef);
    acc_q  <= acc_d;
  end

  // Current section input and the running saturation flag.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= {{(DataW-SampleW-9){sample_i[SampleW-1]}}, sample_i, 9'd0};
      clip_q <= 1'b0;
    end else if (ctrl_i.commit) begin
      x_q    <= sec_y;
      clip_q <= clip_q | sec_sat;
    end
  end

  // History: cleared by reset and by the clear command, shifted at commit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SECTIONS; i++) begin
        x1_q[i] <= '0;
        x2_q[i] <= '0;
        y1_q[i] <= '0;
        y2_q[i] <= '0;
      end
    end else if (clear_i) begin
      for (int i = 0; i < SECTIONS; i++) begin
        x1_q[i] <= '0;
        x2_q[i] <= '0;
        y1_q[i] <= '0;
        y2_q[i] <= '0;
      end
    end else if (ctrl_i.commit) begin
      x2_q[sec_i] <= x1_q[sec_i];
      x1_q[sec_i] <= x_q;
      y2_q[sec_i] <= y1_q[sec_i];
      y1_q[sec_i] <= sec_y;
    end
  end

endmodule

### design/biquad_cascade_iir_filter_unit.sv
// Top level of the cascaded biquad IIR filter: handshakes and result register.
// Instantiates bqc_sequencer and bqc_datapath; uses bqc_pkg.
//
// Filters signed Q1.15 samples through SECTIONS direct-form-I biquad sections
// (default five, a fixed Butterworth band-pass) with Q3.29 coefficients and
// Q8.24 history, saturating every section output and the final 16-bit result;
// clipped_o reports any saturation. A transfer with func_i high clears all
// section history and gives no result. While a filter transfer keeps the
// block busy, one shared 32 x 32 multiplier with its accumulator does the
// five products of each section, one step per cycle from the microcode
// program, then one step subtracts the last registered product and a
// rounding step follows, and one further step forms the output. in_ready_o
// is high whenever no sample is being worked on, also while a result waits
// in the output register; the final step waits only if that register is
// still full.
module biquad_cascade_iir_filter_unit #(
  parameter int unsigned SECTIONS = bqc_pkg::SectionsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               func_i,
  input  logic signed [bqc_pkg::SampleW-1:0] sample_in_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [bqc_pkg::SampleW-1:0] sample_out_o,
  output logic                               clipped_o
);
  import bqc_pkg::*;

  localparam int unsigned SecW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

  logic                      busy;
  logic [SecW-1:0]           sec;
  uword_t                    ctrl;
  logic                      in_xfer;
  logic                      start;
  logic                      clear;
  logic                      stall;
  logic                      load;
  logic signed [SampleW-1:0] dp_sample;
  logic                      dp_clipped;

  logic                      out_valid_q;
  logic signed [SampleW-1:0] sample_out_q;
  logic                      clipped_q;

  // Input side: an item is taken whenever no sample is in progress.
  assign in_ready_o = !busy;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign start      = in_xfer && !func_i;
  assign clear      = in_xfer && func_i;

  // The final step waits while an earlier result has not been taken.
  assign stall = out_valid_q && !out_ready_i;
  assign load  = ctrl.done && !stall;

  bqc_sequencer #(
    .SECTIONS(SECTIONS)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stall_i(stall),
    .busy_o (busy),
    .sec_o  (sec),
    .ctrl_o (ctrl)
  );

  bqc_datapath #(
    .SECTIONS(SECTIONS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .clear_i  (clear),
    .sample_i (sample_in_i),
    .ctrl_i   (ctrl),
    .sec_i    (sec),
    .sample_o (dp_sample),
    .clipped_o(dp_clipped)
  );

  // Output register and its valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sample_out_q <= dp_sample;
      clipped_q    <= dp_clipped;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign clipped_o    = clipped_q;

`ifndef SYNTH
  // A filter transfer starts the program on the next cycle.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> busy)
    else $error("filter transfer did not start the sequencer");

  // A result is loaded only from the final step of a running program.
  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> busy && !ctrl.commit)
    else $error("result loaded outside the final step");

  // A clear command never produces a result.
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear && !out_valid_o |=> !out_valid_o && !busy)
    else $error("clear command produced a result or started work");

  // The section counter never passes the last section.
  a_sec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (sec <= SecW'(SECTIONS - 1)))
    else $error("section counter out of range");
`endif

endmodule
